[rtl/core/crd_pkg.sv]
// Shared types and constants for the camera row deframer.
`default_nettype none

package crd_pkg;

   localparam logic [7:0] SyncFirst  = 8'h59;
   localparam logic [7:0] SyncSecond = 8'h3A;

   localparam logic ReqSerial = 1'b0;
   localparam logic ReqRead   = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
      logic [9:0] read_address;
   } crd_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       link_up;
      logic       row_done;
      logic [5:0] row_written;
   } crd_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FLUSH,
      ST_HOLD
   } crd_state_type;

endpackage

`default_nettype wire

[rtl/core/camera_row_deframer_top.sv]
// Camera row deframer: serial frame parser, row buffer and frame store.
//
//  Port group | Dir | Handshake             | Moves
//  req_       | in  | req_valid / req_ready | serial byte or frame store read
//  rsp_       | out | rsp_valid / rsp_ready | one result per request
//
// Serial byte: ST_HOLD, then the output register. Store read: ST_READ, which takes
// the registered memory output, then ST_HOLD. Byte that completes a frame: ST_COPY,
// the one-entry-per-cycle row copy from the row buffer into the frame store, then
// ST_FLUSH and ST_HOLD. After reset the frame store is zeroed one entry per cycle,
// all ROWS * ROW_BYTES entries (1024 at the defaults), with req_ready low.
// A finished result sits in the output register; the next request is taken meanwhile.
`default_nettype none

module camera_row_deframer_top
   import crd_pkg::*;
#(
   parameter int ROW_BYTES = 16,
   parameter int ROWS      = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire crd_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output crd_rsp_type      rsp_data
);

   localparam int FrameLen = ROW_BYTES + 3;
   localparam int StoreLen = ROWS * ROW_BYTES;
   localparam int PosW     = $clog2(FrameLen);
   localparam int BufAw    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int StoreAw  = (StoreLen > 1) ? $clog2(StoreLen) : 1;

   localparam logic [PosW-1:0]    PosZero  = PosW'(0);
   localparam logic [PosW-1:0]    PosOne   = PosW'(1);
   localparam logic [PosW-1:0]    PosRow   = PosW'(2);
   localparam logic [PosW-1:0]    PosPix   = PosW'(3);
   localparam logic [PosW-1:0]    PosLast  = PosW'(FrameLen - 1);
   localparam logic [BufAw-1:0]   CntLast  = BufAw'(ROW_BYTES - 1);
   localparam logic [StoreAw-1:0] ClrLast  = StoreAw'(StoreLen - 1);

   crd_state_type      state_ff, state_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [7:0]         row_ff, row_in;
   logic               seen_ff, seen_in;
   logic [BufAw-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [BufAw-1:0]   pend_idx_ff, pend_idx_in;
   logic [StoreAw-1:0] base_ff, base_in;
   logic [StoreAw-1:0] clr_ff, clr_in;
   logic               oob_ff, oob_in;
   crd_rsp_type        res_ff, res_in;
   crd_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [7:0]         buf_mem [ROW_BYTES];
   logic               buf_we;
   logic [BufAw-1:0]   buf_wa;
   logic [7:0]         buf_wd;
   logic [7:0]         buf_q;

   logic [7:0]         store_mem [StoreLen];
   logic               st_we;
   logic [StoreAw-1:0] st_wa;
   logic [7:0]         st_wd;
   logic               st_re;
   logic [StoreAw-1:0] st_ra;
   logic [7:0]         st_q;

   logic [PosW-1:0]    pos_eff;
   logic [7:0]         row_map;
   logic               out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign st_ra     = StoreAw'(req_data.read_address);
   assign pos_eff   = (pos_ff == PosOne && req_data.rx_byte != SyncSecond) ? PosZero : pos_ff;
   assign row_map   = ({1'b0, row_ff} >= 9'(ROWS)) ? 8'd0 : row_ff;

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= buf_wd;
      end
      buf_q <= buf_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_wa] <= st_wd;
      end
      if (st_re) begin
         st_q <= store_mem[st_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         seen_ff      <= 1'b0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      pend_idx_ff <= pend_idx_in;
      base_ff     <= base_in;
      oob_ff      <= oob_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      row_in       = row_ff;
      seen_in      = seen_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      base_in      = base_ff;
      clr_in       = clr_ff;
      oob_in       = oob_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      buf_we       = 1'b0;
      buf_wa       = BufAw'(pos_eff - PosPix);
      buf_wd       = req_data.rx_byte;
      st_we        = 1'b0;
      st_wa        = StoreAw'(base_ff + StoreAw'(pend_idx_ff));
      st_wd        = buf_q;
      st_re        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            st_we = 1'b1;
            st_wa = clr_ff;
            st_wd = 8'd0;
            clr_in = clr_ff + StoreAw'(1);
            if (clr_ff == ClrLast) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               res_in.link_up = seen_ff;
               if (req_data.req_type == ReqRead) begin
                  st_re    = 1'b1;
                  oob_in   = 32'(req_data.read_address) >= 32'(StoreLen);
                  state_in = ST_READ;
               end else begin
                  state_in = ST_HOLD;
                  pos_in   = pos_eff;
                  if (pos_eff != PosZero || req_data.rx_byte == SyncFirst) begin
                     if (pos_eff == PosRow) begin
                        row_in = req_data.rx_byte;
                     end
                     if (pos_eff >= PosPix) begin
                        buf_we = 1'b1;
                     end
                     if (pos_eff == PosLast) begin
                        pos_in                = PosZero;
                        seen_in               = 1'b1;
                        cnt_in                = '0;
                        base_in               = StoreAw'(32'(row_map) * ROW_BYTES);
                        res_in.link_up        = 1'b1;
                        res_in.row_done       = 1'b1;
                        res_in.row_written    = row_map[5:0];
                        state_in              = ST_COPY;
                     end else begin
                        pos_in = pos_eff + PosOne;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            res_in.read_data = oob_ff ? 8'd0 : st_q;
            state_in = ST_HOLD;
         end
         ST_COPY: begin
            st_we       = pend_ff;
            pend_in     = 1'b1;
            pend_idx_in = cnt_ff;
            if (cnt_ff == CntLast) begin
               state_in = ST_FLUSH;
            end else begin
               cnt_in = cnt_ff + BufAw'(1);
            end
         end
         ST_FLUSH: begin
            st_we    = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/crd_checker.sv]
// Port-level checks for the camera row deframer, bound to the top level.
`default_nettype none

module crd_checker
   import crd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire crd_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_done_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_done |-> rsp_data.link_up && rsp_data.read_data == 8'd0)
      else $error("row completion without link or with read data");

   a_data_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_data != 8'd0 |-> rsp_data.link_up && !rsp_data.row_done)
      else $error("nonzero frame data before any frame");

   a_row_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.row_done |-> rsp_data.row_written == 6'd0)
      else $error("row index without completion");

endmodule

bind camera_row_deframer_top crd_checker u_crd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[test/camera_row_deframer_top_test.sv]
// Testbench for camera_row_deframer_top: serial framing, row copy and frame store reads.
`timescale 1ns / 1ps

module camera_row_deframer_top_test;
   import crd_pkg::*;

   localparam int ROW_BYTES     = 16;
   localparam int ROWS          = 64;
   localparam int FRAME_BYTES   = ROW_BYTES + 3;
   localparam int STORE_BYTES   = ROWS * ROW_BYTES;
   localparam int ITEM_TARGET   = 1150;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   crd_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   crd_rsp_type rsp_data;

   logic [7:0]  shadow_store [0:STORE_BYTES-1];
   logic [7:0]  shadow_frame [0:FRAME_BYTES-1];
   int unsigned shadow_pos;
   bit          shadow_link;

   crd_rsp_type due_results [$];
   int          errors = 0;
   int          items_sent = 0;
   int          quiet_cycles = 0;
   int          ready_run = 0;

   camera_row_deframer_top #(
      .ROW_BYTES (ROW_BYTES),
      .ROWS      (ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic crd_rsp_type deframe_predict(crd_req_type item);
      crd_rsp_type r;
      int unsigned row;
      r = '0;
      if (item.req_type == ReqRead) begin
         if (item.read_address < STORE_BYTES) r.read_data = shadow_store[item.read_address];
      end else begin
         if (shadow_pos == 1 && item.rx_byte != SyncSecond) shadow_pos = 0;
         if (shadow_pos != 0 || item.rx_byte == SyncFirst) begin
            shadow_frame[shadow_pos] = item.rx_byte;
            shadow_pos++;
            if (shadow_pos == FRAME_BYTES) begin
               shadow_pos = 0;
               shadow_link = 1'b1;
               row = shadow_frame[2];
               if (row >= ROWS) row = 0;
               for (int i = 0; i < ROW_BYTES; i++)
                  shadow_store[row * ROW_BYTES + i] = shadow_frame[3 + i];
               r.row_done = 1'b1;
               r.row_written = row[5:0];
            end
         end
      end
      r.link_up = shadow_link;
      return r;
   endfunction

   // random stalls on the result side
   always @(posedge clock) begin
      if (ready_run > 0) begin
         ready_run <= ready_run - 1;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         ready_run <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
         ready_run <= $urandom_range(0, 40);
      end
   end

   always @(posedge clock) begin
      crd_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_data);
               errors++;
            end else begin
               want = due_results.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data: expected %0h, got %0h", want.read_data, rsp_data.read_data);
                  errors++;
               end
               if (rsp_data.link_up !== want.link_up) begin
                  $error("link_up: expected %0b, got %0b", want.link_up, rsp_data.link_up);
                  errors++;
               end
               if (rsp_data.row_done !== want.row_done) begin
                  $error("row_done: expected %0b, got %0b", want.row_done, rsp_data.row_done);
                  errors++;
               end
               if (rsp_data.row_written !== want.row_written) begin
                  $error("row_written: expected %0d, got %0d",
                         want.row_written, rsp_data.row_written);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) due_results.push_back(deframe_predict(req_data));
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_req(input crd_req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      crd_req_type item;
      item.req_type = ReqSerial;
      item.rx_byte = b;
      item.read_address = 10'($urandom_range(0, 1023));
      send_req(item);
   endtask

   task automatic send_read(input logic [9:0] addr);
      crd_req_type item;
      item.req_type = ReqRead;
      item.rx_byte = 8'($urandom_range(0, 255));
      item.read_address = addr;
      send_req(item);
   endtask

   function automatic logic [7:0] pick_row();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'(ROWS - 1);
            2: return 8'(ROWS);
            default: return 8'hFF;
         endcase
      end
      if (r < 3) return 8'($urandom_range(ROWS, 255));
      return 8'($urandom_range(0, ROWS - 1));
   endfunction

   // sync pair, row number, then pixel_count pixel bytes
   task automatic send_frame(input logic [7:0] row_num, input int pixel_count);
      int style;
      style = $urandom_range(0, 9);
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      send_byte(row_num);
      for (int i = 0; i < pixel_count; i++) begin
         if (style == 0) send_byte(8'h00);
         else if (style == 1) send_byte(8'hFF);
         else send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_empty_store();
      send_read(10'd0);
      send_read(10'h3FF);
   endtask

   // noise, a repeated 'Y' that must be retried as a first byte, row number past the end
   task automatic test_sync_search_and_wrap();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SyncFirst);
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      send_byte(8'hFF);
      for (int i = 0; i < ROW_BYTES; i++) send_byte(i[0] ? 8'hFF : 8'h00);
      send_read(10'd0);
      send_read(10'(ROW_BYTES - 1));
   endtask

   task automatic test_random_traffic();
      int pick;
      logic [7:0] row_num;
      int mapped;
      logic [7:0] b;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            row_num = pick_row();
            send_frame(row_num, ROW_BYTES);
            mapped = (row_num >= ROWS) ? 0 : row_num;
            repeat ($urandom_range(0, 3))
               send_read(10'(mapped * ROW_BYTES + $urandom_range(0, ROW_BYTES - 1)));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4)) send_read(10'($urandom_range(0, 1023)));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            b = 8'($urandom_range(0, 255));
            if (b == SyncSecond) b = SyncFirst;
            send_byte(SyncFirst);
            send_byte(b);
         end else begin
            send_frame(pick_row(), $urandom_range(0, ROW_BYTES - 1));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      shadow_pos = 0;
      shadow_link = 1'b0;
      for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = 8'h00;
      for (int i = 0; i < FRAME_BYTES; i++) shadow_frame[i] = 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_sync_search_and_wrap();
      test_random_traffic();
      req_valid <= 1'b0;

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
